>>> design/draw_signature_top_table_defines.svh
// Assertion macros for the draw signature table block.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef DRAW_SIGNATURE_TOP_TABLE_DEFINES_SVH
`define DRAW_SIGNATURE_TOP_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define DST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/dst_pkg.sv
// Shared types and constants of the draw signature table block.
// No dependencies; used by front, queue, back and top level.
`default_nettype none

package dst_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W        = 3;
    localparam int CNT_W         = 32;
    localparam int ID_W          = 64;
    localparam int METHOD_W      = 3;
    localparam int NUM_CNT       = 7;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // draw method codes
    localparam logic [METHOD_W-1:0] DM_INDEXED      = 3'd0;
    localparam logic [METHOD_W-1:0] DM_PLAIN        = 3'd1;
    localparam logic [METHOD_W-1:0] DM_IDX_INST     = 3'd2;
    localparam logic [METHOD_W-1:0] DM_INSTANCED    = 3'd3;
    localparam logic [METHOD_W-1:0] DM_AUTO         = 3'd4;
    localparam logic [METHOD_W-1:0] DM_IDX_INST_IND = 3'd5;
    localparam logic [METHOD_W-1:0] DM_INST_IND     = 3'd6;

    // slot actions
    localparam logic [1:0] ACT_HIT     = 2'd0;
    localparam logic [1:0] ACT_FILL    = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    // event counter positions
    localparam int CNT_TOTAL     = 0;
    localparam int CNT_INDEXED   = 1;
    localparam int CNT_INSTANCED = 2;
    localparam int CNT_AUTO      = 3;
    localparam int CNT_BLENDED   = 4;
    localparam int CNT_DEPTHW    = 5;
    localparam int CNT_NOLAYOUT  = 6;

    // classified draw event, front to back
    typedef struct packed {
        logic [ID_W-1:0]     layout_id;
        logic [ID_W-1:0]     vertex_id;
        logic [ID_W-1:0]     pixel_id;
        logic [METHOD_W-1:0] draw_method;
        logic [NUM_CNT-1:0]  cls;
    } t_dst_item;

    typedef logic [NUM_CNT-1:0][CNT_W-1:0] t_dst_counters;

endpackage

`default_nettype wire

>>> design/draw_signature_top_table.sv
// Top level of the draw signature table block.
// Depends on dst_pkg, dst_front, dst_queue and dst_back.
`default_nettype none

// Draw signature table. Each draw event on the slave stream is classified into seven
// saturating counters and looked up in an 8-entry signature table (hit counts up,
// miss fills a free entry or replaces the lowest-numbered least-count entry).
// While the probe is on, each event gives one result on the master stream; while it
// is off, events are taken and dropped. Writing the probe from 0 to 1 empties the
// table; the counters keep their values. An event is accepted into a
// two-entry queue; the back end then takes one event at a time (table search and
// least-count pick, then write-back into the result register) and pops the next
// only after the last one is written back; write-back waits while the master stalls.
// There is no clearing pass after reset.
module draw_signature_top_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_wdata,        // probe_enable
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // layout_id[63:0], vertex_id[127:64], pixel_id[191:128], blend_present,
    // blend_enable, src_blend_one, dest_blend_zero, depth_present, depth_enable,
    // depth_mask_all [198:192], zero [199]
    input  wire logic [199:0] i_s_axis_tdata,
    input  wire logic [2:0]   i_s_axis_tuser,     // draw_method
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // slot[2:0], slot_draws, total_draws, indexed_draws, instanced_draws,
    // auto_draws, blended_draws, depth-writing draws, no_layout_draws (32 each), zero
    output logic [263:0]      o_m_axis_tdata,
    output logic [1:0]        o_m_axis_tuser      // slot_action
);

    logic                   q_full, q_push, q_pop, q_valid, tbl_clr;
    dst_pkg::t_dst_item     push_item, head_item;
    logic [dst_pkg::SLOT_W-1:0] slot;
    logic [dst_pkg::CNT_W-1:0]  slot_draws;
    dst_pkg::t_dst_counters counters;

    dst_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_layout_id      (i_s_axis_tdata[63:0]),
        .i_vertex_id      (i_s_axis_tdata[127:64]),
        .i_pixel_id       (i_s_axis_tdata[191:128]),
        .i_draw_method    (i_s_axis_tuser),
        .i_blend_present  (i_s_axis_tdata[192]),
        .i_blend_enable   (i_s_axis_tdata[193]),
        .i_src_blend_one  (i_s_axis_tdata[194]),
        .i_dest_blend_zero(i_s_axis_tdata[195]),
        .i_depth_present  (i_s_axis_tdata[196]),
        .i_depth_enable   (i_s_axis_tdata[197]),
        .i_depth_mask_all (i_s_axis_tdata[198]),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_item         (push_item),
        .o_tbl_clr        (tbl_clr)
    );

    dst_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (push_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_item (head_item)
    );

    dst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tbl_clr    (tbl_clr),
        .i_q_valid    (q_valid),
        .i_q_item     (head_item),
        .o_q_pop      (q_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_slot       (slot),
        .o_slot_action(o_m_axis_tuser),
        .o_slot_draws (slot_draws),
        .o_counters   (counters)
    );

    assign o_m_axis_tdata = {5'd0,
                             counters[dst_pkg::CNT_NOLAYOUT],
                             counters[dst_pkg::CNT_DEPTHW],
                             counters[dst_pkg::CNT_BLENDED],
                             counters[dst_pkg::CNT_AUTO],
                             counters[dst_pkg::CNT_INSTANCED],
                             counters[dst_pkg::CNT_INDEXED],
                             counters[dst_pkg::CNT_TOTAL],
                             slot_draws,
                             slot};

endmodule

`default_nettype wire

>>> design/dst_front.sv
// Front end: holds the probe enable, accepts draw events and classifies them.
// Depends on dst_pkg.
`default_nettype none

module dst_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_wdata,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [dst_pkg::ID_W-1:0]  i_layout_id,
    input  wire logic [dst_pkg::ID_W-1:0]  i_vertex_id,
    input  wire logic [dst_pkg::ID_W-1:0]  i_pixel_id,
    input  wire logic [dst_pkg::METHOD_W-1:0] i_draw_method,
    input  wire logic                      i_blend_present,
    input  wire logic                      i_blend_enable,
    input  wire logic                      i_src_blend_one,
    input  wire logic                      i_dest_blend_zero,
    input  wire logic                      i_depth_present,
    input  wire logic                      i_depth_enable,
    input  wire logic                      i_depth_mask_all,
    input  wire logic                      i_q_full,
    output logic                           o_q_push,
    output dst_pkg::t_dst_item             o_q_item,
    output logic                           o_tbl_clr
);

    logic r_probe;
    logic is_idx, is_inst, is_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= 1'b0;
        end else if (i_cfg_we) begin
            r_probe <= i_cfg_wdata;
        end
    end

    // turning the probe on restarts the table
    assign o_tbl_clr = i_cfg_we && i_cfg_wdata && !r_probe;

    // items taken while the probe is off are dropped
    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full && r_probe;

    always_comb begin
        is_idx  = 1'b0;
        is_inst = 1'b0;
        is_auto = 1'b0;
        unique case (i_draw_method) inside
            dst_pkg::DM_INDEXED: begin
                is_idx = 1'b1;
            end
            dst_pkg::DM_IDX_INST, dst_pkg::DM_IDX_INST_IND, dst_pkg::DM_INST_IND: begin
                is_idx  = 1'b1;
                is_inst = 1'b1;
            end
            dst_pkg::DM_INSTANCED: begin
                is_inst = 1'b1;
            end
            dst_pkg::DM_AUTO: begin
                is_auto = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_q_item             = '0;
        o_q_item.layout_id   = i_layout_id;
        o_q_item.vertex_id   = i_vertex_id;
        o_q_item.pixel_id    = i_pixel_id;
        o_q_item.draw_method = i_draw_method;
        o_q_item.cls[dst_pkg::CNT_TOTAL]     = 1'b1;
        o_q_item.cls[dst_pkg::CNT_INDEXED]   = is_idx;
        o_q_item.cls[dst_pkg::CNT_INSTANCED] = is_inst;
        o_q_item.cls[dst_pkg::CNT_AUTO]      = is_auto;
        o_q_item.cls[dst_pkg::CNT_BLENDED]   = i_blend_present && i_blend_enable &&
                                               !(i_src_blend_one && i_dest_blend_zero);
        o_q_item.cls[dst_pkg::CNT_DEPTHW]    = i_depth_present ?
                                               (i_depth_enable && i_depth_mask_all) : 1'b1;
        o_q_item.cls[dst_pkg::CNT_NOLAYOUT]  = (i_layout_id == '0);
    end

endmodule

`default_nettype wire

>>> design/dst_queue.sv
// Short FIFO of classified draw events between front and back.
// Depends on dst_pkg.
`default_nettype none

module dst_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dst_pkg::t_dst_item i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output dst_pkg::t_dst_item      o_item
);

    dst_pkg::t_dst_item r_mem [dst_pkg::QUEUE_DEPTH];
    logic [dst_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [dst_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == dst_pkg::QCNT_W'(dst_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == dst_pkg::QPTR_W'(dst_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == dst_pkg::QPTR_W'(dst_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/dst_back.sv
// Back end: signature table search, write-back, event counters, result register.
// Depends on dst_pkg and draw_signature_top_table_defines.svh.
`default_nettype none
`include "draw_signature_top_table_defines.svh"

module dst_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_tbl_clr,
    input  wire logic                      i_q_valid,
    input  wire dst_pkg::t_dst_item        i_q_item,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [dst_pkg::SLOT_W-1:0]     o_slot,
    output logic [1:0]                     o_slot_action,
    output logic [dst_pkg::CNT_W-1:0]      o_slot_draws,
    output dst_pkg::t_dst_counters         o_counters
);

    localparam int N = dst_pkg::TABLE_ENTRIES;

    logic [dst_pkg::ID_W-1:0]     r_klay [N];
    logic [dst_pkg::ID_W-1:0]     r_kvtx [N];
    logic [dst_pkg::ID_W-1:0]     r_kpix [N];
    logic [dst_pkg::METHOD_W-1:0] r_kmeth [N];
    logic [dst_pkg::CNT_W-1:0]    r_ecnt [N];
    logic [dst_pkg::FILL_W-1:0]   r_filled;
    dst_pkg::t_dst_counters       r_evt, n_evt;

    // search stage
    logic                         r_a_vld;
    dst_pkg::t_dst_item           r_a_item;
    logic [dst_pkg::IDX_W-1:0]    r_a_slot, n_a_slot;
    logic [1:0]                   r_a_act, n_a_act;
    logic [dst_pkg::CNT_W-1:0]    r_a_cnt, n_a_cnt;

    // result register
    logic                         r_out_vld;
    logic [dst_pkg::IDX_W-1:0]    r_out_slot;
    logic [1:0]                   r_out_act;
    logic [dst_pkg::CNT_W-1:0]    r_out_cnt;

    logic [N-1:0]                 match, is_min;
    logic                         hit;
    logic [dst_pkg::IDX_W-1:0]    hit_idx, min_idx;
    logic                         a_adv;

    function automatic logic [dst_pkg::FILL_W-1:0] FILL_W_EXT(input int idx);
        return dst_pkg::FILL_W'(idx);
    endfunction

    // one event in the search/write loop at a time
    assign o_q_pop = i_q_valid && !r_a_vld;
    assign a_adv   = r_a_vld && (!r_out_vld || i_ready);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = (FILL_W_EXT(i) < r_filled) &&
                       r_klay[i] == i_q_item.layout_id &&
                       r_kvtx[i] == i_q_item.vertex_id &&
                       r_kpix[i] == i_q_item.pixel_id &&
                       r_kmeth[i] == i_q_item.draw_method;
            // lowest-numbered entry with the least count
            is_min[i] = 1'b1;
            for (int j = 0; j < N; j++) begin
                if (j < i && !(r_ecnt[i] < r_ecnt[j])) begin
                    is_min[i] = 1'b0;
                end
                if (j > i && r_ecnt[j] < r_ecnt[i]) begin
                    is_min[i] = 1'b0;
                end
            end
        end
        hit     = 1'b0;
        hit_idx = '0;
        min_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = dst_pkg::IDX_W'(i);
            end
            if (is_min[i]) begin
                min_idx = dst_pkg::IDX_W'(i);
            end
        end
        if (hit) begin
            n_a_slot = hit_idx;
            n_a_act  = dst_pkg::ACT_HIT;
            n_a_cnt  = (r_ecnt[hit_idx] == dst_pkg::CNT_MAX) ?
                       dst_pkg::CNT_MAX : r_ecnt[hit_idx] + 1'b1;
        end else if (r_filled < dst_pkg::FILL_W'(N)) begin
            n_a_slot = r_filled[dst_pkg::IDX_W-1:0];
            n_a_act  = dst_pkg::ACT_FILL;
            n_a_cnt  = dst_pkg::CNT_W'(1);
        end else begin
            n_a_slot = min_idx;
            n_a_act  = dst_pkg::ACT_REPLACE;
            n_a_cnt  = dst_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        for (int c = 0; c < dst_pkg::NUM_CNT; c++) begin
            n_evt[c] = (r_a_item.cls[c] && r_evt[c] != dst_pkg::CNT_MAX) ?
                       r_evt[c] + 1'b1 : r_evt[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_item <= i_q_item;
            r_a_slot <= n_a_slot;
            r_a_act  <= n_a_act;
            r_a_cnt  <= n_a_cnt;
        end
        if (a_adv) begin
            r_ecnt[r_a_slot] <= r_a_cnt;
            if (r_a_act != dst_pkg::ACT_HIT) begin
                r_klay[r_a_slot]  <= r_a_item.layout_id;
                r_kvtx[r_a_slot]  <= r_a_item.vertex_id;
                r_kpix[r_a_slot]  <= r_a_item.pixel_id;
                r_kmeth[r_a_slot] <= r_a_item.draw_method;
            end
            r_out_slot <= r_a_slot;
            r_out_act  <= r_a_act;
            r_out_cnt  <= r_a_cnt;
        end
        if (!i_rst_n) begin
            r_filled  <= '0;
            r_evt     <= '0;
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_tbl_clr) begin
                r_filled <= '0;
            end else if (a_adv && r_a_act == dst_pkg::ACT_FILL) begin
                r_filled <= r_filled + 1'b1;
            end
            if (a_adv) begin
                r_evt <= n_evt;
            end
            if (o_q_pop) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (a_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_slot        = dst_pkg::SLOT_W'(r_out_slot);
    assign o_slot_action = r_out_act;
    assign o_slot_draws  = r_out_cnt;
    assign o_counters    = r_evt;

    `DST_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_filled <= dst_pkg::FILL_W'(N), "fill count beyond table size")
    `DST_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, r_a_vld, !o_q_pop, "second event entered search stage")
    `DST_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, a_adv, r_out_vld, "write-back produced no result")
    `DST_ASSERT_IMP(a_replace_full, i_clk, i_rst_n, r_a_vld && r_a_act == dst_pkg::ACT_REPLACE, r_filled == dst_pkg::FILL_W'(N), "replacement with free entries left")

endmodule

`default_nettype wire
